// File: src/sch_pkg.sv
package sch_pkg;

    localparam int NPROC_DEF    = 32;
    localparam int FUNC_W       = 3;
    localparam int AMOUNT_W     = 16;
    localparam int SEM_ID_W     = 4;
    localparam int STATUS_W     = 2;
    localparam int PID_W        = 5;
    localparam int TICK_W       = 32;
    localparam int RUN_W        = 16;
    localparam int CFG_W        = 16;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 3;

    localparam logic [SEM_ID_W-1:0] SCREEN_SEM     = 4'd1;
    localparam logic [CFG_W-1:0]    TIME_SLICE_RST = 16'd10;
    localparam logic [CFG_W-1:0]    SEM_INIT_RST   = 16'd0;
    localparam logic [CFG_W-1:0]    SEM_MAX        = 16'hFFFF;

    localparam logic REG_TIME_SLICE  = 1'b0;
    localparam logic REG_SEM_INITIAL = 1'b1;

    typedef enum logic [2:0] {
        F_CREATE   = 3'd0,
        F_TICK     = 3'd1,
        F_SLEEP    = 3'd2,
        F_SEM_WAIT = 3'd3,
        F_SEM_POST = 3'd4,
        F_GET_PID  = 3'd5,
        F_DISPATCH = 3'd6
    } t_func;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOFREE = 2'd1,
        ST_NOSEM  = 2'd2,
        ST_NORUN  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        PS_FREE  = 3'd0,
        PS_READY = 3'd1,
        PS_RUN   = 3'd2,
        PS_SLEEP = 3'd3,
        PS_WAIT  = 3'd4
    } t_pst;

    typedef struct packed {
        t_pst              st;
        logic [TICK_W-1:0] wake;
        logic [RUN_W-1:0]  run;
    } t_pent;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_POP,
        S_MOD,
        S_FINISH
    } t_state;

endpackage

// File: src/sch_if.sv
interface sch_in_if;
    logic                          valid;
    logic                          ready;
    logic [sch_pkg::FUNC_W-1:0]    func;
    logic [sch_pkg::AMOUNT_W-1:0]  amount;
    logic [sch_pkg::SEM_ID_W-1:0]  sem_id;

    modport source (output valid, func, amount, sem_id, input ready);
    modport sink (input valid, func, amount, sem_id, output ready);
endinterface

interface sch_out_if;
    logic                          valid;
    logic                          ready;
    logic [sch_pkg::STATUS_W-1:0]  status;
    logic [sch_pkg::PID_W-1:0]     pid;
    logic                          running_valid;

    modport source (output valid, status, pid, running_valid, input ready);
    modport sink (input valid, status, pid, running_valid, output ready);
endinterface

// File: src/process_scheduler_with_semaphore.sv
// Round-robin task-state manager with one counting semaphore. After reset the block clears
// its process table and accepts no item until that is done. Sleep and sem_wait read and
// rewrite the entry of the running process when they take it off the processor; sem_post
// that wakes a waiting process first pops the wait queue, then reads and rewrites its entry;
// dispatch reads and rewrites the idle entry when it falls back to idle, and otherwise pops
// the ready queue first. A tick walks the process table one entry per cycle through the single
// read port of the table memory, then updates the entry of the running process when a process
// other than idle is running. A new item is taken while the previous result still waits in
// the output register, but that item cannot finish until the waiting result has been transferred.
module process_scheduler_with_semaphore #(
    parameter int NPROC = sch_pkg::NPROC_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    sch_in_if.sink                          i_in,
    sch_out_if.source                       o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sch_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [sch_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [sch_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import sch_pkg::*;

    localparam int IW = $clog2(NPROC);

    t_state                r_state, n_state;
    t_func                 r_func, n_func;
    logic [AMOUNT_W-1:0]   r_amount, n_amount;
    logic [SEM_ID_W-1:0]   r_sem_id, n_sem_id;
    t_status               r_status, n_status;
    logic [IW-1:0]         r_pid, n_pid;
    logic [IW-1:0]         r_tgt, n_tgt;
    logic [IW:0]           r_scan, n_scan;
    logic                  r_pv, n_pv;
    logic [IW-1:0]         r_paddr, n_paddr;
    logic [TICK_W-1:0]     r_tick, n_tick;
    logic [CFG_W-1:0]      r_sem, n_sem;
    logic [CFG_W-1:0]      r_slice, n_slice;
    logic [CFG_W-1:0]      r_sem_init, n_sem_init;
    logic                  r_run_valid, n_run_valid;
    logic [IW-1:0]         r_run_id, n_run_id;
    logic [IW:0]           r_free_next, n_free_next;
    logic [IW-1:0]         r_clr, n_clr;
    logic                  r_ov, n_ov;
    logic [STATUS_W-1:0]   r_o_status, n_o_status;
    logic [PID_W-1:0]      r_o_pid, n_o_pid;
    logic                  r_o_rv, n_o_rv;

    logic                  tab_rd;
    logic [IW-1:0]         tab_raddr;
    t_pent                 tab_rdata;
    logic                  tab_we;
    logic [IW-1:0]         tab_waddr;
    t_pent                 tab_wdata;
    logic                  rq_push, rq_pop, rq_empty, rq_full;
    logic [IW-1:0]         rq_id, rq_data;
    logic                  wq_push, wq_pop, wq_empty, wq_full;
    logic [IW-1:0]         wq_data;
    logic                  cfg_we;
    logic [IW+PID_W-1:0]   pid_ext;

    sch_ptab #(.DEPTH(NPROC), .IW(IW)) u_ptab (
        .i_clk     (i_clk),
        .i_rd_en   (tab_rd),
        .i_rd_addr (tab_raddr),
        .o_rd_data (tab_rdata),
        .i_wr_en   (tab_we),
        .i_wr_addr (tab_waddr),
        .i_wr_data (tab_wdata)
    );

    sch_idq #(.DEPTH(NPROC), .IW(IW)) u_ready_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (rq_push),
        .i_push_id (rq_id),
        .i_pop     (rq_pop),
        .o_pop_id  (rq_data),
        .o_empty   (rq_empty),
        .o_full    (rq_full)
    );

    sch_idq #(.DEPTH(NPROC), .IW(IW)) u_wait_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (wq_push),
        .i_push_id (r_run_id),
        .i_pop     (wq_pop),
        .o_pop_id  (wq_data),
        .o_empty   (wq_empty),
        .o_full    (wq_full)
    );

    assign pready        = 1'b1;
    assign cfg_we        = psel && penable && pwrite;
    assign prdata        = (paddr[2] == REG_SEM_INITIAL) ? {16'b0, r_sem_init}
                                                         : {16'b0, r_slice};
    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_ov;
    assign o_out.status  = r_o_status;
    assign o_out.pid     = r_o_pid;
    assign o_out.running_valid = r_o_rv;
    assign pid_ext       = {{PID_W{1'b0}}, r_pid};

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_amount    = r_amount;
        n_sem_id    = r_sem_id;
        n_status    = r_status;
        n_pid       = r_pid;
        n_tgt       = r_tgt;
        n_scan      = r_scan;
        n_pv        = r_pv;
        n_paddr     = r_paddr;
        n_tick      = r_tick;
        n_sem       = r_sem;
        n_slice     = r_slice;
        n_sem_init  = r_sem_init;
        n_run_valid = r_run_valid;
        n_run_id    = r_run_id;
        n_free_next = r_free_next;
        n_clr       = r_clr;
        n_ov        = r_ov;
        n_o_status  = r_o_status;
        n_o_pid     = r_o_pid;
        n_o_rv      = r_o_rv;
        tab_rd      = 1'b0;
        tab_raddr   = r_tgt;
        tab_we      = 1'b0;
        tab_waddr   = r_tgt;
        tab_wdata   = tab_rdata;
        rq_push     = 1'b0;
        rq_id       = r_tgt;
        rq_pop      = 1'b0;
        wq_push     = 1'b0;
        wq_pop      = 1'b0;

        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                tab_we    = 1'b1;
                tab_waddr = r_clr;
                tab_wdata = '{PS_FREE, '0, '0};
                n_clr     = r_clr + 1'b1;
                if (r_clr == IW'(NPROC-1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    n_func   = t_func'(i_in.func);
                    n_amount = i_in.amount;
                    n_sem_id = i_in.sem_id;
                    n_status = ST_OK;
                    n_pid    = '0;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_FINISH;
                case (r_func)
                    F_CREATE: begin
                        if (r_free_next == (IW+1)'(NPROC)) begin
                            n_status = ST_NOFREE;
                        end else begin
                            tab_we      = 1'b1;
                            tab_waddr   = r_free_next[IW-1:0];
                            tab_wdata   = '{PS_READY, '0, '0};
                            rq_id       = r_free_next[IW-1:0];
                            rq_push     = (r_free_next[IW-1:0] != '0);
                            n_pid       = r_free_next[IW-1:0];
                            n_free_next = r_free_next + 1'b1;
                        end
                    end
                    F_TICK: begin
                        n_tick  = r_tick + 1'b1;
                        n_scan  = '0;
                        n_pv    = 1'b0;
                        n_state = S_SCAN;
                    end
                    F_SLEEP: begin
                        if (!r_run_valid) begin
                            n_status = ST_NORUN;
                        end else if (r_run_id != '0) begin
                            tab_rd    = 1'b1;
                            tab_raddr = r_run_id;
                            n_tgt     = r_run_id;
                            n_state   = S_MOD;
                        end
                    end
                    F_SEM_WAIT: begin
                        if (r_sem_id != SCREEN_SEM) begin
                            n_status = ST_NOSEM;
                        end else if (r_sem != '0) begin
                            n_sem = r_sem - 1'b1;
                        end else if (!r_run_valid) begin
                            n_status = ST_NORUN;
                        end else if (r_run_id != '0) begin
                            wq_push   = 1'b1;
                            tab_rd    = 1'b1;
                            tab_raddr = r_run_id;
                            n_tgt     = r_run_id;
                            n_state   = S_MOD;
                        end
                    end
                    F_SEM_POST: begin
                        if (r_sem_id != SCREEN_SEM) begin
                            n_status = ST_NOSEM;
                        end else if (wq_empty) begin
                            if (r_sem != SEM_MAX) begin
                                n_sem = r_sem + 1'b1;
                            end
                        end else begin
                            wq_pop  = 1'b1;
                            n_state = S_POP;
                        end
                    end
                    F_GET_PID: begin
                        if (!r_run_valid) begin
                            n_status = ST_NORUN;
                        end else begin
                            n_pid = r_run_id;
                        end
                    end
                    F_DISPATCH: begin
                        if (r_run_valid) begin
                            n_pid = r_run_id;
                        end else if (rq_empty) begin
                            tab_rd    = 1'b1;
                            tab_raddr = '0;
                            n_tgt     = '0;
                            n_state   = S_MOD;
                        end else begin
                            rq_pop  = 1'b1;
                            n_state = S_POP;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                if (r_scan != (IW+1)'(NPROC)) begin
                    tab_rd    = 1'b1;
                    tab_raddr = r_scan[IW-1:0];
                    n_scan    = r_scan + 1'b1;
                end
                n_pv    = (r_scan != (IW+1)'(NPROC));
                n_paddr = r_scan[IW-1:0];
                if (r_pv && tab_rdata.st == PS_SLEEP && tab_rdata.wake == r_tick) begin
                    tab_we       = 1'b1;
                    tab_waddr    = r_paddr;
                    tab_wdata.st = PS_READY;
                    rq_id        = r_paddr;
                    rq_push      = (r_paddr != '0);
                end
                if (r_scan == (IW+1)'(NPROC) && !r_pv) begin
                    if (r_run_valid && r_run_id != '0) begin
                        tab_rd    = 1'b1;
                        tab_raddr = r_run_id;
                        n_tgt     = r_run_id;
                        n_state   = S_MOD;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_POP: begin
                tab_rd    = 1'b1;
                tab_raddr = (r_func == F_SEM_POST) ? wq_data : rq_data;
                n_tgt     = tab_raddr;
                n_state   = S_MOD;
            end
            S_MOD: begin
                tab_we  = 1'b1;
                n_state = S_FINISH;
                case (r_func)
                    F_TICK: begin
                        tab_wdata.run = tab_rdata.run + 1'b1;
                        if (tab_wdata.run == r_slice) begin
                            tab_wdata.st = PS_READY;
                            rq_push      = 1'b1;
                            n_run_valid  = 1'b0;
                        end
                    end
                    F_SLEEP: begin
                        tab_wdata.st   = PS_SLEEP;
                        tab_wdata.wake = r_tick + {16'b0, r_amount};
                        n_run_valid    = 1'b0;
                    end
                    F_SEM_WAIT: begin
                        tab_wdata.st = PS_WAIT;
                        n_run_valid  = 1'b0;
                    end
                    F_SEM_POST: begin
                        tab_wdata.st = PS_READY;
                        rq_push      = (r_tgt != '0);
                    end
                    F_DISPATCH: begin
                        tab_wdata.st  = PS_RUN;
                        tab_wdata.run = '0;
                        n_run_id      = r_tgt;
                        n_run_valid   = 1'b1;
                        n_pid         = r_tgt;
                    end
                    default: begin
                        tab_we = 1'b0;
                    end
                endcase
            end
            S_FINISH: begin
                if (!r_ov || o_out.ready) begin
                    n_ov       = 1'b1;
                    n_o_status = r_status;
                    n_o_pid    = pid_ext[PID_W-1:0];
                    n_o_rv     = r_run_valid;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (cfg_we) begin
            if (paddr[2] == REG_SEM_INITIAL) begin
                n_sem_init = pwdata[CFG_W-1:0];
                n_sem      = pwdata[CFG_W-1:0];
            end else begin
                n_slice = pwdata[CFG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
        end else begin
            r_state     <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick      <= '0;
            r_sem       <= SEM_INIT_RST;
            r_slice     <= TIME_SLICE_RST;
            r_sem_init  <= SEM_INIT_RST;
            r_run_valid <= 1'b0;
            r_run_id    <= '0;
            r_free_next <= '0;
            r_clr       <= '0;
            r_ov        <= 1'b0;
            r_scan      <= '0;
            r_pv        <= 1'b0;
        end else begin
            r_tick      <= n_tick;
            r_sem       <= n_sem;
            r_slice     <= n_slice;
            r_sem_init  <= n_sem_init;
            r_run_valid <= n_run_valid;
            r_run_id    <= n_run_id;
            r_free_next <= n_free_next;
            r_clr       <= n_clr;
            r_ov        <= n_ov;
            r_scan      <= n_scan;
            r_pv        <= n_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_amount   <= n_amount;
        r_sem_id   <= n_sem_id;
        r_status   <= n_status;
        r_pid      <= n_pid;
        r_tgt      <= n_tgt;
        r_paddr    <= n_paddr;
        r_o_status <= n_o_status;
        r_o_pid    <= n_o_pid;
        r_o_rv     <= n_o_rv;
    end

    a_no_accept_in_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !i_in.ready)
        else $error("item accepted during the table clearing pass");

    a_free_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_next <= (IW+1)'(NPROC))
        else $error("free id counter ran past the table depth");

    a_finish_to_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && (!r_ov || o_out.ready)) |=> o_out.valid)
        else $error("finished item did not reach the output register");

    a_no_queue_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(rq_push && rq_full) && !(wq_push && wq_full))
        else $error("push into a full id queue");
endmodule

// File: src/sch_idq.sv
module sch_idq #(
    parameter int DEPTH = sch_pkg::NPROC_DEF,
    parameter int IW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [IW-1:0] i_push_id,
    input  logic          i_pop,
    output logic [IW-1:0] o_pop_id,
    output logic          o_empty,
    output logic          o_full
);
    logic [IW-1:0] r_mem [DEPTH];
    logic [IW-1:0] r_head;
    logic [IW-1:0] r_tail;
    logic [IW:0]   r_cnt;
    logic [IW-1:0] r_rd;
    logic          do_push;
    logic          do_pop;

    assign o_empty  = (r_cnt == '0);
    assign o_full   = (r_cnt == (IW+1)'(DEPTH));
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && !o_empty;
    assign o_pop_id = r_rd;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_tail] <= i_push_id;
        end
        if (do_pop) begin
            r_rd <= r_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_tail <= (r_tail == IW'(DEPTH-1)) ? '0 : r_tail + 1'b1;
            end
            if (do_pop) begin
                r_head <= (r_head == IW'(DEPTH-1)) ? '0 : r_head + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

// File: src/sch_ptab.sv
module sch_ptab #(
    parameter int DEPTH = sch_pkg::NPROC_DEF,
    parameter int IW    = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rd_en,
    input  logic [IW-1:0]         i_rd_addr,
    output sch_pkg::t_pent        o_rd_data,
    input  logic                  i_wr_en,
    input  logic [IW-1:0]         i_wr_addr,
    input  sch_pkg::t_pent        i_wr_data
);
    import sch_pkg::*;

    t_pent r_mem [DEPTH];
    t_pent r_rd;

    assign o_rd_data = r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end
endmodule

// File: bench/tb_process_scheduler_with_semaphore.sv
`timescale 1ns / 100ps

module tb_process_scheduler_with_semaphore;
    import sch_pkg::*;

    localparam int NP          = NPROC_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 300;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [PID_W-1:0]    pid;
        logic                rv;
    } t_result;

    typedef struct {
        logic [FUNC_W-1:0]   f;
        logic [AMOUNT_W-1:0] a;
        logic [SEM_ID_W-1:0] s;
        bit                  typed;
        t_result             r;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    sch_in_if  in_if ();
    sch_out_if out_if ();

    process_scheduler_with_semaphore #(.NPROC(NP)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_pst                mdl_state [NP];
    logic [TICK_W-1:0]   mdl_wake [NP];
    logic [RUN_W-1:0]    mdl_run [NP];
    int                  free_ids [$];
    int                  ready_ids [$];
    int                  sem_waiters [$];
    logic [CFG_W-1:0]    mdl_sem_count;
    logic [CFG_W-1:0]    mdl_slice;
    logic [TICK_W-1:0]   mdl_ticks;
    bit                  mdl_running;
    int                  mdl_run_id;

    t_result             pending_results [$];
    t_result             oldest;
    int                  errors;
    int                  cycles;
    int                  burst_left;
    int                  stall_hold;
    bit                  stall_on;

    t_row dir_rows [0:24] = '{
        '{F_GET_PID,  16'd0,     4'd0,  1'b1, '{ST_NORUN, 5'd0, 1'b0}},
        '{F_SLEEP,    16'hFFFF,  4'd0,  1'b1, '{ST_NORUN, 5'd0, 1'b0}},
        '{F_SEM_WAIT, 16'd0,     4'd0,  1'b1, '{ST_NOSEM, 5'd0, 1'b0}},
        '{F_SEM_POST, 16'd0,     4'd15, 1'b1, '{ST_NOSEM, 5'd0, 1'b0}},
        '{F_SEM_WAIT, 16'd0,     4'd1,  1'b1, '{ST_NORUN, 5'd0, 1'b0}},
        '{F_TICK,     16'd0,     4'd0,  1'b1, '{ST_OK,    5'd0, 1'b0}},
        '{F_CREATE,   16'd0,     4'd0,  1'b1, '{ST_OK,    5'd0, 1'b0}},
        '{F_CREATE,   16'd0,     4'd0,  1'b1, '{ST_OK,    5'd1, 1'b0}},
        '{F_CREATE,   16'hFFFF,  4'd15, 1'b1, '{ST_OK,    5'd2, 1'b0}},
        '{F_DISPATCH, 16'd0,     4'd0,  1'b1, '{ST_OK,    5'd1, 1'b1}},
        '{F_GET_PID,  16'd0,     4'd0,  1'b1, '{ST_OK,    5'd1, 1'b1}},
        '{F_DISPATCH, 16'd0,     4'd0,  1'b1, '{ST_OK,    5'd1, 1'b1}},
        '{F_SEM_POST, 16'd0,     4'd1,  1'b0, '{ST_OK,    5'd0, 1'b0}},
        '{F_SEM_WAIT, 16'd0,     4'd1,  1'b0, '{ST_OK,    5'd0, 1'b0}},
        '{F_SEM_WAIT, 16'd0,     4'd1,  1'b1, '{ST_OK,    5'd0, 1'b0}},
        '{F_DISPATCH, 16'd0,     4'd0,  1'b0, '{ST_OK,    5'd0, 1'b0}},
        '{F_SEM_POST, 16'd0,     4'd1,  1'b0, '{ST_OK,    5'd0, 1'b0}},
        '{F_SLEEP,    16'd0,     4'd0,  1'b0, '{ST_OK,    5'd0, 1'b0}},
        '{F_DISPATCH, 16'd0,     4'd0,  1'b0, '{ST_OK,    5'd0, 1'b0}},
        '{3'd7,       16'hFFFF,  4'd15, 1'b1, '{ST_OK,    5'd0, 1'b1}},
        '{F_TICK,     16'd0,     4'd0,  1'b0, '{ST_OK,    5'd0, 1'b0}},
        '{F_TICK,     16'd0,     4'd0,  1'b0, '{ST_OK,    5'd0, 1'b0}},
        '{F_SLEEP,    16'd1,     4'd0,  1'b0, '{ST_OK,    5'd0, 1'b0}},
        '{F_TICK,     16'd0,     4'd0,  1'b0, '{ST_OK,    5'd0, 1'b0}},
        '{F_DISPATCH, 16'd0,     4'd0,  1'b0, '{ST_OK,    5'd0, 1'b0}}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void make_ready(int id);
        mdl_state[id] = PS_READY;
        if (id != 0 && ready_ids.size() < NP) ready_ids.push_back(id);
    endfunction

    task automatic schedule_step(input logic [FUNC_W-1:0] f, input logic [AMOUNT_W-1:0] amt,
                                 input logic [SEM_ID_W-1:0] sid, output t_result r);
        int id;
        r = '{ST_OK, 5'd0, 1'b0};
        case (f)
            F_CREATE: begin
                if (free_ids.size() == 0) begin
                    r.status = ST_NOFREE;
                end else begin
                    id = free_ids.pop_front();
                    mdl_wake[id] = '0;
                    mdl_run[id] = '0;
                    make_ready(id);
                    r.pid = PID_W'(id);
                end
            end
            F_TICK: begin
                mdl_ticks = mdl_ticks + 1'b1;
                for (int i = 0; i < NP; i++) begin
                    if (mdl_state[i] == PS_SLEEP && mdl_wake[i] == mdl_ticks) make_ready(i);
                end
                if (mdl_running && mdl_run_id != 0) begin
                    mdl_run[mdl_run_id] = mdl_run[mdl_run_id] + 1'b1;
                    if (mdl_run[mdl_run_id] == mdl_slice) begin
                        make_ready(mdl_run_id);
                        mdl_running = 1'b0;
                    end
                end
            end
            F_SLEEP: begin
                if (!mdl_running) begin
                    r.status = ST_NORUN;
                end else if (mdl_run_id != 0) begin
                    mdl_wake[mdl_run_id] = mdl_ticks + TICK_W'(amt);
                    mdl_state[mdl_run_id] = PS_SLEEP;
                    mdl_running = 1'b0;
                end
            end
            F_SEM_WAIT: begin
                if (sid != SCREEN_SEM) begin
                    r.status = ST_NOSEM;
                end else if (mdl_sem_count > 0) begin
                    mdl_sem_count = mdl_sem_count - 1'b1;
                end else if (!mdl_running) begin
                    r.status = ST_NORUN;
                end else if (mdl_run_id != 0) begin
                    if (sem_waiters.size() < NP) sem_waiters.push_back(mdl_run_id);
                    mdl_state[mdl_run_id] = PS_WAIT;
                    mdl_running = 1'b0;
                end
            end
            F_SEM_POST: begin
                if (sid != SCREEN_SEM) begin
                    r.status = ST_NOSEM;
                end else if (sem_waiters.size() == 0) begin
                    if (mdl_sem_count != SEM_MAX) mdl_sem_count = mdl_sem_count + 1'b1;
                end else begin
                    make_ready(sem_waiters.pop_front());
                end
            end
            F_GET_PID: begin
                if (!mdl_running) r.status = ST_NORUN;
                else r.pid = PID_W'(mdl_run_id);
            end
            F_DISPATCH: begin
                if (!mdl_running) begin
                    id = 0;
                    if (ready_ids.size() != 0) id = ready_ids.pop_front();
                    mdl_run_id = id;
                    mdl_running = 1'b1;
                    mdl_state[id] = PS_RUN;
                    mdl_run[id] = '0;
                end
                r.pid = PID_W'(mdl_run_id);
            end
            default: ;
        endcase
        r.rv = mdl_running;
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result transfer with nothing expected");
            end else begin
                oldest = pending_results.pop_front();
                if (out_if.status !== oldest.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              out_if.status, oldest.status));
                if (out_if.pid !== oldest.pid)
                    report_mismatch($sformatf("pid %0d, expected %0d", out_if.pid, oldest.pid));
                if (out_if.running_valid !== oldest.rv)
                    report_mismatch($sformatf("running_valid %0b, expected %0b",
                                              out_if.running_valid, oldest.rv));
            end
        end
        if (stall_hold == 0) begin
            stall_hold = $urandom_range(1, 30);
            stall_on = ($urandom_range(0, 3) == 0);
        end
        stall_hold--;
        out_if.ready <= !stall_on;
    end

    task automatic send_item(input logic [FUNC_W-1:0] f, input logic [AMOUNT_W-1:0] a,
                             input logic [SEM_ID_W-1:0] s, input bit typed, input t_result te);
        t_result r;
        int gap;
        in_if.valid  <= 1'b1;
        in_if.func   <= f;
        in_if.amount <= a;
        in_if.sem_id <= s;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        schedule_step(f, a, s, r);
        pending_results.push_back(typed ? te : r);
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic send_checked(input logic [FUNC_W-1:0] f, input logic [AMOUNT_W-1:0] a,
                                input logic [SEM_ID_W-1:0] s);
        send_item(f, a, s, 1'b0, '{ST_OK, 5'd0, 1'b0});
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2 * NP) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic idx, input logic [CFG_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_TIME_SLICE) begin
            mdl_slice = val;
        end else begin
            mdl_sem_count = val;
        end
        @(posedge i_clk);
    endtask

    task automatic pick_item(output logic [FUNC_W-1:0] f, output logic [AMOUNT_W-1:0] a,
                             output logic [SEM_ID_W-1:0] s);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) f = F_CREATE;
        else if (roll < 38) f = F_TICK;
        else if (roll < 48) f = F_SLEEP;
        else if (roll < 60) f = F_SEM_WAIT;
        else if (roll < 73) f = F_SEM_POST;
        else if (roll < 79) f = F_GET_PID;
        else if (roll < 97) f = F_DISPATCH;
        else f = FUNC_W'($urandom_range(0, 7));
        roll = $urandom_range(0, 99);
        if (roll < 80) a = AMOUNT_W'($urandom_range(1, 8));
        else if (roll < 95) a = AMOUNT_W'($urandom_range(0, 100));
        else a = AMOUNT_W'($urandom);
        s = ($urandom_range(0, 6) == 0) ? SEM_ID_W'($urandom_range(0, 15)) : SCREEN_SEM;
        if (f == F_DISPATCH && !mdl_running && ready_ids.size() == 0) begin
            if (sem_waiters.size() != 0) begin
                f = F_SEM_POST;
                s = SCREEN_SEM;
            end else begin
                f = F_TICK;
            end
        end
    endtask

    task automatic random_phase(input int count, input bit hold_off);
        logic [FUNC_W-1:0]   f;
        logic [AMOUNT_W-1:0] a;
        logic [SEM_ID_W-1:0] s;
        for (int n = 0; n < count; n++) begin
            if (hold_off && n == count / 2) drain();
            pick_item(f, a, s);
            send_checked(f, a, s);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_if.valid   = 1'b0;
        in_if.func    = '0;
        in_if.amount  = '0;
        in_if.sem_id  = '0;
        out_if.ready  = 1'b0;
        errors        = 0;
        cycles        = 0;
        stall_hold    = 0;
        stall_on      = 1'b0;
        burst_left    = 5;
        for (int i = 0; i < NP; i++) begin
            mdl_state[i] = PS_FREE;
            mdl_wake[i]  = '0;
            mdl_run[i]   = '0;
            free_ids.push_back(i);
        end
        mdl_slice     = TIME_SLICE_RST;
        mdl_sem_count = SEM_INIT_RST;
        mdl_ticks     = '0;
        mdl_running   = 1'b0;
        mdl_run_id    = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k])
            send_item(dir_rows[k].f, dir_rows[k].a, dir_rows[k].s, dir_rows[k].typed,
                      dir_rows[k].r);
        random_phase(PHASE_ITEMS / 2, 1'b0);
        drain();

        apb_write(REG_TIME_SLICE, 16'd1);
        apb_write(REG_SEM_INITIAL, SEM_MAX);
        random_phase(PHASE_ITEMS, 1'b1);
        drain();
        apb_write(REG_TIME_SLICE, 16'hFFFF);
        apb_write(REG_SEM_INITIAL, 16'd0);
        random_phase(PHASE_ITEMS, 1'b0);
        drain();
        apb_write(REG_TIME_SLICE, CFG_W'($urandom_range(2, 8)));
        apb_write(REG_SEM_INITIAL, CFG_W'($urandom_range(0, 3)));
        random_phase(PHASE_ITEMS, 1'b0);
        drain();
        apb_write(REG_TIME_SLICE, 16'd3);
        apb_write(REG_SEM_INITIAL, 16'd0);
        random_phase(PHASE_ITEMS, 1'b0);

        // Park every process so that idle takes over, then exercise the idle cases.
        while (!(mdl_running && mdl_run_id == 0)) begin
            if (mdl_running) send_checked(F_SLEEP, 16'hFFFF, SCREEN_SEM);
            else send_checked(F_DISPATCH, 16'd0, SCREEN_SEM);
        end
        while (mdl_sem_count != 0) send_checked(F_SEM_WAIT, 16'd0, SCREEN_SEM);
        send_checked(F_SEM_WAIT, 16'd0, SCREEN_SEM);
        send_checked(F_SLEEP, 16'd4, SCREEN_SEM);
        send_checked(F_TICK, 16'd0, SCREEN_SEM);
        send_checked(F_DISPATCH, 16'd0, SCREEN_SEM);
        send_checked(F_GET_PID, 16'd0, SCREEN_SEM);
        send_checked(F_CREATE, 16'd0, SCREEN_SEM);
        drain();

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: process_scheduler_with_semaphore.f
src/sch_pkg.sv
src/sch_if.sv
src/sch_idq.sv
src/sch_ptab.sv
src/process_scheduler_with_semaphore.sv
bench/tb_process_scheduler_with_semaphore.sv
